// File: sv/hse_pkg.sv
// Shared types and constants for the heap sort engine.
package hse_pkg;

    localparam int HSE_DEPTH = 64;
    localparam int DATA_W    = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } hse_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_run;
        logic                     overflow;
    } hse_out_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_BUILD_RD,
        S_BUILD_LD,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_NEXT,
        S_SORT_RD,
        S_SORT_SWAP,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } hse_state_t;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_LOAD,
        DP_BUILD_INIT,
        DP_BUILD_RD,
        DP_LOAD_X,
        DP_SORT_INIT,
        DP_SORT_RD,
        DP_SORT_SWAP,
        DP_SIFT_RD,
        DP_SIFT_CMP,
        DP_ITER_DEC,
        DP_OUT_INIT,
        DP_OUT_RD,
        DP_OUT_LD,
        DP_OUT_NEXT,
        DP_CLEAR
    } hse_op_t;

    typedef struct packed {
        hse_op_t op;
    } hse_cmd_t;

    typedef struct packed {
        logic few_items;
        logic leaf;
        logic settled;
        logic iter_one;
        logic iter_last;
    } hse_status_t;

endpackage

// File: sv/hse_datapath.sv
// Datapath of the heap sort engine: element memory, heap indices and output register.
module hse_datapath import hse_pkg::*; #(
    parameter int DEPTH = HSE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  hse_in_t     s_data,
    input  hse_cmd_t    cmd,
    output hse_out_t    m_data,
    output hse_status_t status
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CHILD_W = CNT_W + 1;

    logic signed [DATA_W-1:0] store_mem [DEPTH];

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic [CNT_W-1:0]  iter_reg, iter_next;
    logic [ADDR_W-1:0] node_reg, node_next;
    logic [CNT_W-1:0]  limit_reg, limit_next;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] rd_a_reg, rd_b_reg;
    hse_out_t          out_reg, out_next;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0]        rd_a_addr, rd_b_addr;

    logic [CHILD_W-1:0]       left_idx, right_idx;
    logic                     leaf, right_ok, left_gt, right_gt, settled;
    logic signed [DATA_W-1:0] cand_val, big_val;
    logic [ADDR_W-1:0]        big_idx;
    logic [CNT_W-1:0]         iter_dec, count_dec;
    logic                     iter_last;

    // Children of the current node and the max-of-three decision for one sift level.
    assign left_idx  = CHILD_W'({node_reg, 1'b1});
    assign right_idx = left_idx + 1'b1;
    assign leaf      = left_idx >= CHILD_W'(limit_reg);
    assign right_ok  = right_idx < CHILD_W'(limit_reg);
    assign left_gt   = rd_a_reg > x_reg;
    assign cand_val  = left_gt ? rd_a_reg : x_reg;
    assign right_gt  = right_ok && (rd_b_reg > cand_val);
    assign settled   = !left_gt && !right_gt;
    assign big_val   = right_gt ? rd_b_reg : rd_a_reg;
    assign big_idx   = right_gt ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];

    assign iter_dec  = iter_reg - 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign iter_last = iter_reg == count_dec;

    always_comb begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        iter_next    = iter_reg;
        node_next    = node_reg;
        limit_next   = limit_reg;
        x_next       = x_reg;
        out_next     = out_reg;
        wr_en        = 1'b0;
        wr_addr      = node_reg;
        wr_data      = x_reg;
        rd_a_addr    = '0;
        rd_b_addr    = '0;
        case (cmd.op)
            DP_LOAD: begin
                if (count_reg < CNT_W'(DEPTH)) begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[ADDR_W-1:0];
                    wr_data    = s_data.value;
                    count_next = count_reg + 1'b1;
                end else begin
                    dropped_next = 1'b1;
                end
            end
            DP_BUILD_INIT: begin
                iter_next  = count_reg >> 1;
                limit_next = count_reg;
            end
            DP_BUILD_RD: begin
                node_next = iter_dec[ADDR_W-1:0];
                rd_a_addr = iter_dec[ADDR_W-1:0];
            end
            DP_LOAD_X: begin
                x_next = rd_a_reg;
            end
            DP_SORT_INIT: begin
                iter_next = count_dec;
            end
            DP_SORT_RD: begin
                rd_a_addr = '0;
                rd_b_addr = iter_reg[ADDR_W-1:0];
            end
            DP_SORT_SWAP: begin
                // The old root goes to the end of the heap; the last entry is sifted from the root.
                wr_en      = 1'b1;
                wr_addr    = iter_reg[ADDR_W-1:0];
                wr_data    = rd_a_reg;
                x_next     = rd_b_reg;
                node_next  = '0;
                limit_next = iter_reg;
            end
            DP_SIFT_RD: begin
                rd_a_addr = leaf ? '0 : left_idx[ADDR_W-1:0];
                rd_b_addr = right_ok ? right_idx[ADDR_W-1:0] : '0;
                if (leaf) begin
                    wr_en = 1'b1;
                end
            end
            DP_SIFT_CMP: begin
                // The held value stays out of memory until its final place is known.
                wr_en   = 1'b1;
                wr_data = settled ? x_reg : big_val;
                if (!settled) begin
                    node_next = big_idx;
                end
            end
            DP_ITER_DEC: begin
                iter_next = iter_dec;
            end
            DP_OUT_INIT: begin
                iter_next = '0;
            end
            DP_OUT_RD: begin
                rd_a_addr = iter_reg[ADDR_W-1:0];
            end
            DP_OUT_LD: begin
                out_next.sorted_value = rd_a_reg;
                out_next.end_of_run   = iter_last;
                out_next.overflow     = dropped_reg;
            end
            DP_OUT_NEXT: begin
                iter_next = iter_reg + 1'b1;
            end
            DP_CLEAR: begin
                count_next   = '0;
                dropped_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge aclk) begin
        iter_reg  <= iter_next;
        node_reg  <= node_next;
        limit_reg <= limit_next;
        x_reg     <= x_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= store_mem[rd_a_addr];
        rd_b_reg <= store_mem[rd_b_addr];
    end

    assign m_data = out_reg;

    always_comb begin
        status.few_items = count_reg < CNT_W'(2);
        status.leaf      = leaf;
        status.settled   = settled;
        status.iter_one  = iter_reg == CNT_W'(1);
        status.iter_last = iter_last;
    end

endmodule

// File: sv/hse_ctrl.sv
// Controller of the heap sort engine: sequences loading, heap build, sort-down and output.
module hse_ctrl import hse_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_is_last,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  hse_status_t status,
    output hse_cmd_t    cmd
);

    hse_state_t state_reg, state_next;
    logic       sort_phase_reg, sort_phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            sort_phase_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sort_phase_reg <= sort_phase_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        sort_phase_next = sort_phase_reg;
        cmd.op          = DP_IDLE;
        s_ready         = 1'b0;
        m_valid         = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = DP_LOAD;
                    if (s_is_last) begin
                        state_next = S_START;
                    end
                end
            end
            S_START: begin
                sort_phase_next = 1'b0;
                if (status.few_items) begin
                    cmd.op     = DP_OUT_INIT;
                    state_next = S_OUT_RD;
                end else begin
                    cmd.op     = DP_BUILD_INIT;
                    state_next = S_BUILD_RD;
                end
            end
            S_BUILD_RD: begin
                cmd.op     = DP_BUILD_RD;
                state_next = S_BUILD_LD;
            end
            S_BUILD_LD: begin
                cmd.op     = DP_LOAD_X;
                state_next = S_SIFT_RD;
            end
            S_SIFT_RD: begin
                cmd.op     = DP_SIFT_RD;
                state_next = status.leaf ? S_NEXT : S_SIFT_CMP;
            end
            S_SIFT_CMP: begin
                cmd.op     = DP_SIFT_CMP;
                state_next = status.settled ? S_NEXT : S_SIFT_RD;
            end
            S_NEXT: begin
                if (!sort_phase_reg) begin
                    if (status.iter_one) begin
                        cmd.op          = DP_SORT_INIT;
                        sort_phase_next = 1'b1;
                    end else begin
                        cmd.op = DP_ITER_DEC;
                    end
                    state_next = status.iter_one ? S_SORT_RD : S_BUILD_RD;
                end else begin
                    if (status.iter_one) begin
                        cmd.op     = DP_OUT_INIT;
                        state_next = S_OUT_RD;
                    end else begin
                        cmd.op     = DP_ITER_DEC;
                        state_next = S_SORT_RD;
                    end
                end
            end
            S_SORT_RD: begin
                cmd.op     = DP_SORT_RD;
                state_next = S_SORT_SWAP;
            end
            S_SORT_SWAP: begin
                cmd.op     = DP_SORT_SWAP;
                state_next = S_SIFT_RD;
            end
            S_OUT_RD: begin
                cmd.op     = DP_OUT_RD;
                state_next = S_OUT_LD;
            end
            S_OUT_LD: begin
                cmd.op     = DP_OUT_LD;
                state_next = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.iter_last) begin
                        cmd.op     = DP_CLEAR;
                        state_next = S_LOAD;
                    end else begin
                        cmd.op     = DP_OUT_NEXT;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

// File: sv/heap_sort_engine.sv
// Heap sort engine top level: loads a set, heap-sorts it and streams it out ascending.
// Values are taken one per cycle into a DEPTH-entry memory until the transfer flagged
// is_last; values beyond DEPTH are dropped and the whole run is flagged as overflowed.
// The set of n values is then sorted in place: n/2 sift-downs build a max-heap and n-1
// root swaps, each followed by a sift-down, sort it. Each sift level reads both children,
// then compares and writes back, as the memory has one write port and two registered
// read ports. The sorted values then leave one at a time, each read from memory, loaded
// into the output register and held until it is taken, the last one marked end_of_run.
// No input is taken from the closing input transfer until the final result has been
// transferred.
module heap_sort_engine import hse_pkg::*; #(
    parameter int DEPTH = HSE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hse_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output hse_out_t m_data
);

    hse_cmd_t    cmd;
    hse_status_t status;

    hse_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_is_last (s_data.is_last),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    hse_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .m_data  (m_data),
        .status  (status)
    );

    // Loading and draining never overlap.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("result offered while input is being taken");

    // The closing transfer of a set stops further input until the run is out.
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.is_last) |=> !s_ready)
        else $error("input still taken after the last element of a set");

    // After the final result the engine is ready for the next set at once.
    a_run_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.end_of_run) |=> (s_ready && !m_valid))
        else $error("engine not ready for a new set after end of run");

endmodule
